// ----- rtl/core/tde_pkg.sv -----
// Shared constants, codes and types of the trie dictionary engine.
`default_nettype none
package tde_pkg;

  localparam int NODE_POOL_DEF   = 4096;
  localparam int WORD_LENGTH_DEF = 10;
  localparam int ALPHABET_DEF    = 26;

  localparam int LETTER_W = 5;
  localparam int LEN_W    = 4;
  localparam int COUNT_W  = 24;
  localparam int VALUE_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_QUERY  = 3'd1,
    ACT_COUNT  = 3'd2,
    ACT_VALUE  = 3'd3,
    ACT_DELETE = 3'd4,
    ACT_UNIQUE = 3'd5,
    ACT_CLEAR  = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_POOL_FULL  = 3'd2,
    ST_BAD_LETTER = 3'd3,
    ST_COUNT_FULL = 3'd4
  } status_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             bad;
  } word_info_t;

endpackage
`default_nettype wire

// ----- rtl/core/tde_ram.sv -----
// Generic single-port-write, single-port-read memory with a registered read.
`default_nettype none
module tde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/tde_decode.sv -----
// Word decode: clamps the word length and flags letter codes outside the alphabet.
`default_nettype none
module tde_decode
  import tde_pkg::*;
#(
  parameter int WORD_LENGTH = WORD_LENGTH_DEF,
  parameter int ALPHABET    = ALPHABET_DEF
) (
  input  wire logic [LETTER_W*WORD_LENGTH-1:0] letters,
  input  wire logic [LEN_W-1:0]                word_length,
  output word_info_t                           info
);

  logic [LEN_W-1:0] len;

  always_comb begin
    len = (word_length > LEN_W'(WORD_LENGTH)) ? LEN_W'(WORD_LENGTH) : word_length;
    info.len = len;
    info.bad = 1'b0;
    for (int j = 0; j < WORD_LENGTH; j++) begin
      if ((LEN_W'(j) < len) &&
          ({1'b0, letters[LETTER_W*j +: LETTER_W]} >= (LETTER_W+1)'(ALPHABET))) begin
        info.bad = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/trie_dictionary_engine_unit.sv -----
// Top level of the trie dictionary engine: sequencer around the link and node memories.
`default_nettype none
// The engine keeps a trie of words in two memories: a link memory with one child pointer per
// node and letter, and a node memory holding each node's pass count, word mark, stored value
// and a parent tag (parent node and letter). One transaction on the input carries a whole word
// and an action; exactly one result transaction follows for each. The block works on one word
// at a time. Each level of the word is walked through the states S_LINK, S_NODE and S_EVAL (read
// the link, read the child node, evaluate and write back), so the walk over the node memory
// sets the rate. A query, prefix count, value query or unique prefix makes one walk over the
// word, an insert a checking walk, the pool check and a modifying walk, a delete a checking walk
// and a modifying walk, and a clear, an unused action or a word with a bad letter goes straight
// to the result. The input is ready again in the cycle after the result is handed to the output
// register. The next word is accepted while a finished result still waits in the output
// register. No clearing pass is needed after reset or clear: a link is trusted only when it
// points below the allocation pointer and the child's parent tag names the node and letter
// it was read from, and the root's word mark lives in a register. Freed nodes are never reused
// until a clear.
module trie_dictionary_engine_unit
  import tde_pkg::*;
#(
  parameter int NODE_POOL   = NODE_POOL_DEF,
  parameter int WORD_LENGTH = WORD_LENGTH_DEF,
  parameter int ALPHABET    = ALPHABET_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [2:0]                      in_action,
  input  wire logic [LETTER_W*WORD_LENGTH-1:0] in_letters,
  input  wire logic [LEN_W-1:0]                in_word_length,
  input  wire logic signed [VALUE_W-1:0]       in_value_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [2:0]                           out_status,
  output logic                                 out_is_word,
  output logic [COUNT_W-1:0]                   out_prefix_count,
  output logic signed [VALUE_W-1:0]            out_value_out,
  output logic [LEN_W-1:0]                     out_unique_len
);

  localparam int NW   = $clog2(NODE_POOL);
  localparam int NFW  = NW + 1;
  localparam int LAW  = $clog2(NODE_POOL * ALPHABET);
  localparam int WL_W = LETTER_W * WORD_LENGTH;

  typedef struct packed {
    logic [NW-1:0]       key_node;
    logic [LETTER_W-1:0] key_letter;
    logic                mark;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  count;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [2:0] {
    S_IDLE, S_LINK, S_NODE, S_EVAL, S_CHECK, S_END, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  action_t act_r, act_nxt;
  logic [LEN_W-1:0] len_r, len_nxt, i_r, i_nxt, need_r, need_nxt;
  logic [NW-1:0] n_r, n_nxt, c_r, c_nxt;
  logic [WL_W-1:0] letters_r, letters_nxt, cur_r, cur_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic phase2_r, phase2_nxt, full_r, full_nxt;
  logic [NFW-1:0] next_free_r, next_free_nxt;
  logic [VALUE_W:0] root_mark_r, root_mark_nxt;
  logic [COUNT_W-1:0] end_count_r, end_count_nxt;
  logic end_mark_r, end_mark_nxt;
  logic [VALUE_W-1:0] end_value_r, end_value_nxt;
  status_t res_status_r, res_status_nxt;
  logic res_is_word_r, res_is_word_nxt;
  logic [COUNT_W-1:0] res_count_r, res_count_nxt;
  logic [VALUE_W-1:0] res_value_r, res_value_nxt;
  logic [LEN_W-1:0] res_ulen_r, res_ulen_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r;
  logic out_is_word_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [LEN_W-1:0] out_ulen_r;

  word_info_t info;
  logic [LETTER_W-1:0] letter;
  logic [LAW-1:0] link_raddr, link_waddr;
  logic [NW-1:0] link_rdata, link_wdata, node_waddr;
  logic link_we, node_we;
  logic [NODE_W-1:0] node_rdata;
  node_t nd, wd;
  logic link_ok, live, last;
  logic [LEN_W-1:0] i_inc;
  logic [COUNT_W-1:0] sub_count;

  tde_decode #(.WORD_LENGTH(WORD_LENGTH), .ALPHABET(ALPHABET)) u_decode (
    .letters     (in_letters),
    .word_length (in_word_length),
    .info        (info)
  );

  tde_ram #(.WIDTH(NW), .DEPTH(NODE_POOL * ALPHABET)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  tde_ram #(.WIDTH(NODE_W), .DEPTH(NODE_POOL)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (wd),
    .raddr (link_rdata),
    .rdata (node_rdata)
  );

  // The link being followed: node n_r, current letter at the bottom of the shift register.
  assign letter     = cur_r[LETTER_W-1:0];
  assign link_raddr = LAW'(n_r) * LAW'(ALPHABET) + LAW'(letter);
  assign link_waddr = link_raddr;
  assign nd         = node_t'(node_rdata);
  assign i_inc      = i_r + LEN_W'(1);
  assign last       = (i_inc == len_r);
  assign link_ok    = (c_r != '0) && ({1'b0, c_r} < next_free_r) &&
                      (nd.key_node == n_r) && (nd.key_letter == letter);
  assign live       = link_ok && (nd.count != '0);
  assign sub_count  = (nd.count > end_count_r) ? (nd.count - end_count_r) : '0;
  assign in_ready   = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;   act_nxt = act_r;       len_nxt = len_r;
    i_nxt = i_r;           need_nxt = need_r;     n_nxt = n_r;
    c_nxt = c_r;           letters_nxt = letters_r; cur_nxt = cur_r;
    value_nxt = value_r;   phase2_nxt = phase2_r; full_nxt = full_r;
    next_free_nxt = next_free_r;  root_mark_nxt = root_mark_r;
    end_count_nxt = end_count_r;  end_mark_nxt = end_mark_r;
    end_value_nxt = end_value_r;
    res_status_nxt = res_status_r; res_is_word_nxt = res_is_word_r;
    res_count_nxt = res_count_r;   res_value_nxt = res_value_r;
    res_ulen_nxt = res_ulen_r;
    out_valid_nxt = out_valid_r && !out_ready;
    link_we = 1'b0;
    link_wdata = '0;
    node_we = 1'b0;
    node_waddr = c_r;
    wd = nd;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt = action_t'(in_action);
          len_nxt = info.len;
          letters_nxt = in_letters;
          cur_nxt = in_letters;
          value_nxt = in_value_in;
          i_nxt = '0;
          n_nxt = '0;
          need_nxt = '0;
          phase2_nxt = 1'b0;
          full_nxt = 1'b0;
          end_count_nxt = '0;
          end_mark_nxt = root_mark_r[VALUE_W];
          end_value_nxt = root_mark_r[VALUE_W-1:0];
          res_status_nxt = ST_OK;
          res_is_word_nxt = 1'b0;
          res_count_nxt = '0;
          res_value_nxt = '1;
          res_ulen_nxt = '0;
          case (action_t'(in_action))
            ACT_INSERT, ACT_QUERY, ACT_COUNT, ACT_VALUE, ACT_DELETE, ACT_UNIQUE: begin
              if (info.bad) begin
                res_status_nxt = ST_BAD_LETTER;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_LINK;
              end
            end
            ACT_CLEAR: begin
              next_free_nxt = NFW'(1);
              root_mark_nxt = {1'b0, {VALUE_W{1'b1}}};
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_LINK: begin
        state_nxt = (i_r == len_r) ? S_END : S_NODE;
      end
      S_NODE: begin
        c_nxt = link_rdata;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        n_nxt = c_r;
        i_nxt = i_inc;
        cur_nxt = cur_r >> LETTER_W;
        state_nxt = S_LINK;
        case (act_r)
          ACT_INSERT: begin
            if (!phase2_r) begin
              if (link_ok) begin
                if (nd.count == COUNT_MAX) begin
                  full_nxt = 1'b1;
                end
              end else begin
                need_nxt = len_r - i_r;
                state_nxt = S_CHECK;
              end
            end else if (link_ok) begin
              node_we = 1'b1;
              wd.count = nd.count + COUNT_W'(1);
              if (last) begin
                wd.mark = 1'b1;
                if (nd.value == '1) begin
                  wd.value = value_r;
                end
              end
            end else begin
              // Missing child: take the next free node and link it in.
              link_we = 1'b1;
              link_wdata = next_free_r[NW-1:0];
              node_we = 1'b1;
              node_waddr = next_free_r[NW-1:0];
              wd.key_node = n_r;
              wd.key_letter = letter;
              wd.count = COUNT_W'(1);
              wd.mark = last;
              wd.value = last ? value_r : '1;
              n_nxt = next_free_r[NW-1:0];
              next_free_nxt = next_free_r + NFW'(1);
            end
          end
          ACT_QUERY, ACT_COUNT, ACT_VALUE, ACT_DELETE: begin
            if (!phase2_r) begin
              // A link read from a never-written entry is treated as missing.
              if (live) begin
                end_count_nxt = nd.count;
                end_mark_nxt = nd.mark;
                end_value_nxt = nd.value;
              end else begin
                res_status_nxt = ST_NOT_FOUND;
                state_nxt = S_DONE;
              end
            end else if (link_ok) begin
              node_we = 1'b1;
              wd.count = sub_count;
              if (sub_count == '0) begin
                link_we = 1'b1;
                link_wdata = '0;
                state_nxt = S_DONE;
              end
            end else begin
              state_nxt = S_DONE;
            end
          end
          ACT_UNIQUE: begin
            if (live) begin
              if (nd.count == COUNT_W'(1)) begin
                res_ulen_nxt = i_inc;
                state_nxt = S_DONE;
              end
            end else begin
              res_status_nxt = ST_NOT_FOUND;
              res_ulen_nxt = '0;
              state_nxt = S_DONE;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_CHECK: begin
        if (full_r) begin
          res_status_nxt = ST_COUNT_FULL;
          state_nxt = S_DONE;
        end else if ((NFW+1)'(need_r) + (NFW+1)'(next_free_r) > (NFW+1)'(NODE_POOL)) begin
          res_status_nxt = ST_POOL_FULL;
          state_nxt = S_DONE;
        end else begin
          phase2_nxt = 1'b1;
          i_nxt = '0;
          n_nxt = '0;
          cur_nxt = letters_r;
          state_nxt = S_LINK;
        end
      end
      S_END: begin
        state_nxt = S_DONE;
        case (act_r)
          ACT_INSERT: begin
            if (!phase2_r) begin
              state_nxt = S_CHECK;
            end else if (len_r == '0) begin
              root_mark_nxt[VALUE_W] = 1'b1;
              if (root_mark_r[VALUE_W-1:0] == '1) begin
                root_mark_nxt[VALUE_W-1:0] = value_r;
              end
            end
          end
          ACT_QUERY: begin
            res_is_word_nxt = end_mark_r;
            res_status_nxt = end_mark_r ? ST_OK : ST_NOT_FOUND;
          end
          ACT_COUNT: begin
            res_count_nxt = end_count_r;
            res_status_nxt = (end_count_r == '0) ? ST_NOT_FOUND : ST_OK;
          end
          ACT_VALUE: begin
            res_value_nxt = end_value_r;
          end
          ACT_DELETE: begin
            if (!phase2_r) begin
              if (end_count_r == '0) begin
                res_status_nxt = ST_NOT_FOUND;
              end else begin
                // Second walk subtracts the prefix count held in end_count_r.
                res_count_nxt = end_count_r;
                phase2_nxt = 1'b1;
                i_nxt = '0;
                n_nxt = '0;
                cur_nxt = letters_r;
                state_nxt = S_LINK;
              end
            end
          end
          ACT_UNIQUE: begin
            res_ulen_nxt = len_r;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      next_free_r <= NFW'(1);
      root_mark_r <= {1'b0, {VALUE_W{1'b1}}};
      phase2_r    <= 1'b0;
      full_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      next_free_r <= next_free_nxt;
      root_mark_r <= root_mark_nxt;
      phase2_r    <= phase2_nxt;
      full_r      <= full_nxt;
      act_r       <= act_nxt;
      len_r       <= len_nxt;
      i_r         <= i_nxt;
      need_r      <= need_nxt;
      n_r         <= n_nxt;
      c_r         <= c_nxt;
      letters_r   <= letters_nxt;
      cur_r       <= cur_nxt;
      value_r     <= value_nxt;
      end_count_r <= end_count_nxt;
      end_mark_r  <= end_mark_nxt;
      end_value_r <= end_value_nxt;
      res_status_r  <= res_status_nxt;
      res_is_word_r <= res_is_word_nxt;
      res_count_r   <= res_count_nxt;
      res_value_r   <= res_value_nxt;
      res_ulen_r    <= res_ulen_nxt;
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
        out_status_r  <= res_status_r;
        out_is_word_r <= res_is_word_r;
        out_count_r   <= res_count_r;
        out_value_r   <= res_value_r;
        out_ulen_r    <= res_ulen_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_is_word      = out_is_word_r;
  assign out_prefix_count = out_count_r;
  assign out_value_out    = out_value_r;
  assign out_unique_len   = out_ulen_r;

`ifndef SYNTH
  // The allocation pointer never leaves the pool and never points at the root.
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    (next_free_r != '0) && (next_free_r <= NFW'(NODE_POOL)))
    else $error("allocation pointer out of range");

  // A clear transaction empties the pool at once.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_action == ACT_CLEAR)) |=> (next_free_r == NFW'(1)))
    else $error("clear did not reset the allocation pointer");

  // Memories are only written during the second walk of an insert or delete.
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (node_we || link_we) |-> (state_r == S_EVAL) && phase2_r)
    else $error("memory written outside a modifying walk");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/trie_dictionary_engine_unit_tb.sv -----
// Self-checking testbench of the trie dictionary engine, with its own trie predictor.
module trie_dictionary_engine_unit_tb;
  import tde_pkg::*;

  // The block answers every word transaction with exactly one result transaction. This bench
  // keeps a behavioural trie of its own, works out each answer when the word is accepted and
  // compares the answers in order. A short table of directed words comes first. Random words
  // follow: mostly built over a few letters so that paths are shared, and drawn from words
  // already stored, so that queries, counts and deletes find something to work on.

  localparam int POOL   = NODE_POOL_DEF;
  localparam int WLEN   = WORD_LENGTH_DEF;
  localparam int ALPHA  = ALPHABET_DEF;
  localparam int LW     = LETTER_W * WLEN;
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam logic [31:0] UNSET = 32'hFFFF_FFFF;
  localparam int RANDOM_ITEMS = 1930;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 3_000_000;

  typedef struct {
    status_t          status;
    logic             is_word;
    logic [COUNT_W-1:0] count;
    logic [31:0]      value;
    logic [LEN_W-1:0] ulen;
  } answer_t;

  // One row of the directed table. Where typed is set, the answer given here is checked and
  // the predictor is still run so that its trie keeps step with the block.
  typedef struct {
    logic [2:0]       act;
    logic [LW-1:0]    letters;
    logic [LEN_W-1:0] len;
    logic [31:0]      value;
    bit               typed;
    answer_t          ans;
  } row_t;

  typedef struct {
    logic [LW-1:0]    letters;
    logic [LEN_W-1:0] len;
  } word_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] in_action = '0;
  logic [LW-1:0] in_letters = '0;
  logic [LEN_W-1:0] in_word_length = '0;
  logic signed [VALUE_W-1:0] in_value_in = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [2:0] out_status;
  logic out_is_word;
  logic [COUNT_W-1:0] out_prefix_count;
  logic signed [VALUE_W-1:0] out_value_out;
  logic [LEN_W-1:0] out_unique_len;

  trie_dictionary_engine_unit dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_letters, .in_word_length,
    .in_value_in, .out_valid, .out_ready, .out_status, .out_is_word, .out_prefix_count,
    .out_value_out, .out_unique_len
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Shadow trie. Nodes at or above the allocation pointer are cleared when allocated, so a
  // clear only has to empty the root and reset the pointer.
  int unsigned kid [POOL*ALPHA];
  int unsigned passes [POOL];
  bit          marked [POOL];
  logic [31:0] stored [POOL];
  int unsigned alloc_ptr;

  answer_t     pending_answers [$];
  word_t       known_words [$];
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_req = 0;
  int          failures = 0;
  int unsigned cycles = 0;

  function automatic void empty_node(int unsigned n);
    for (int c = 0; c < ALPHA; c++) kid[n*ALPHA+c] = 0;
    passes[n] = 0;
    marked[n] = 0;
    stored[n] = UNSET;
  endfunction

  function automatic void empty_trie();
    empty_node(0);
    alloc_ptr = 1;
  endfunction

  function automatic answer_t blank_answer(status_t st);
    answer_t a;
    a.status = st;
    a.is_word = 0;
    a.count = '0;
    a.value = UNSET;
    a.ulen = '0;
    return a;
  endfunction

  // Applies one word transaction to the shadow trie and returns the answer it causes.
  function automatic answer_t apply_word(logic [2:0] act, logic [LW-1:0] lt,
                                         logic [LEN_W-1:0] wl, logic [31:0] val);
    answer_t a;
    int unsigned code [WLEN];
    int unsigned len, n, c, need, depth, cnt;
    bit bad, full;
    a = blank_answer(ST_OK);
    len = (wl > WLEN) ? WLEN : wl;
    bad = 0;
    for (int i = 0; i < WLEN; i++) code[i] = lt[LETTER_W*i +: LETTER_W];
    for (int i = 0; i < len; i++) if (code[i] >= ALPHA) bad = 1;
    if (act == ACT_CLEAR) begin
      empty_trie();
    end else if (act == ACT_UNUSED) begin
      // Nothing happens; the answer keeps its fixed values.
    end else if (bad) begin
      a.status = ST_BAD_LETTER;
    end else if (act == ACT_INSERT) begin
      need = 0;
      full = 0;
      n = 0;
      for (int i = 0; i < len; i++) begin
        c = kid[n*ALPHA+code[i]];
        if (c == 0) begin
          need = len - i;
          break;
        end
        if (passes[c] >= COUNT_MAX) full = 1;
        n = c;
      end
      if (full) a.status = ST_COUNT_FULL;
      else if (alloc_ptr > POOL - need) a.status = ST_POOL_FULL;
      else begin
        n = 0;
        for (int i = 0; i < len; i++) begin
          c = kid[n*ALPHA+code[i]];
          if (c == 0) begin
            c = alloc_ptr++;
            empty_node(c);
            kid[n*ALPHA+code[i]] = c;
          end
          passes[c] = (passes[c] + 1) & COUNT_MAX;
          n = c;
        end
        if (stored[n] == UNSET) stored[n] = val;
        marked[n] = 1;
      end
    end else if (act == ACT_UNIQUE) begin
      n = 0;
      a.ulen = LEN_W'(len);
      for (int i = 0; i < len; i++) begin
        c = kid[n*ALPHA+code[i]];
        if (c == 0 || passes[c] == 0) begin
          a.status = ST_NOT_FOUND;
          a.ulen = 0;
          break;
        end
        n = c;
        if (passes[n] == 1) begin
          a.ulen = LEN_W'(i + 1);
          break;
        end
      end
    end else begin
      // Walk over live nodes only; a link to a node whose count fell to zero is dead.
      n = 0;
      depth = 0;
      for (int i = 0; i < len; i++) begin
        c = kid[n*ALPHA+code[i]];
        if (c == 0 || passes[c] == 0) break;
        n = c;
        depth++;
      end
      if (depth < len) a.status = ST_NOT_FOUND;
      else if (act == ACT_QUERY) begin
        a.is_word = marked[n];
        if (!marked[n]) a.status = ST_NOT_FOUND;
      end else if (act == ACT_COUNT) begin
        a.count = COUNT_W'(passes[n]);
        if (passes[n] == 0) a.status = ST_NOT_FOUND;
      end else if (act == ACT_VALUE) begin
        a.value = stored[n];
      end else begin
        cnt = passes[n];
        if (cnt == 0) a.status = ST_NOT_FOUND;
        else begin
          a.count = COUNT_W'(cnt);
          n = 0;
          for (int i = 0; i < len; i++) begin
            c = kid[n*ALPHA+code[i]];
            if (c == 0) break;
            passes[c] = (passes[c] > cnt) ? passes[c] - cnt : 0;
            if (passes[c] == 0) begin
              kid[n*ALPHA+code[i]] = 0;
              break;
            end
            n = c;
          end
        end
      end
    end
    return a;
  endfunction

  // Packs a word given as text; the letter slots past its end are filled at random.
  function automatic logic [LW-1:0] spell(string s);
    logic [LW-1:0] lt;
    lt = LW'({$urandom, $urandom});
    for (int i = 0; i < s.len() && i < WLEN; i++)
      lt[LETTER_W*i +: LETTER_W] = LETTER_W'(s[i] - "a");
    return lt;
  endfunction

  // Offers one word transaction, with idle cycles before it, and waits for its acceptance.
  task automatic offer(logic [2:0] act, logic [LW-1:0] lt, logic [LEN_W-1:0] wl,
                       logic [31:0] val, bit typed, answer_t typed_ans);
    answer_t a;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_action <= act;
    in_letters <= lt;
    in_word_length <= wl;
    in_value_in <= val;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    a = apply_word(act, lt, wl, val);
    pending_answers.push_back(typed ? typed_ans : a);
    if (act == ACT_INSERT && a.status == ST_OK && known_words.size() < 200)
      known_words.push_back('{lt, wl});
    if (act == ACT_CLEAR) known_words.delete();
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Random word: mostly a stored word, a prefix or an extension of it (never when wide), else
  // a fresh word, narrow-alphabet unless wide; now and then a bad letter or an overlong length.
  task automatic random_word(bit wide, output logic [LW-1:0] lt, output logic [LEN_W-1:0] wl);
    word_t w;
    int sel;
    lt = LW'({$urandom, $urandom});
    sel = $urandom_range(99);
    if (!wide && known_words.size() != 0 && sel < 60) begin
      w = known_words[$urandom_range(known_words.size() - 1)];
      lt = w.letters;
      wl = w.len;
      if (sel < 20 && wl != 0) wl = LEN_W'($urandom_range(wl - 1));
      else if (sel < 30 && wl < WLEN) begin
        lt[LETTER_W*wl +: LETTER_W] = LETTER_W'($urandom_range(2));
        wl = wl + LEN_W'(1);
      end
    end else begin
      wl = wide ? LEN_W'(WLEN) : LEN_W'($urandom_range(WLEN));
      for (int i = 0; i < WLEN; i++)
        lt[LETTER_W*i +: LETTER_W] =
          LETTER_W'(wide ? $urandom_range(ALPHA - 1) : $urandom_range(3));
      if ($urandom_range(99) < 6) lt[LETTER_W*$urandom_range(WLEN - 1) +: LETTER_W] =
        LETTER_W'($urandom_range(31, ALPHA));
      if ($urandom_range(99) < 4) wl = LEN_W'($urandom_range(15, WLEN + 1));
    end
  endtask

  task automatic random_phase(int items, int filling);
    logic [LW-1:0] lt;
    logic [LEN_W-1:0] wl;
    logic [2:0] act;
    int r;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(999);
      if (k < filling) act = ACT_INSERT;
      else if (r < 350) act = ACT_INSERT;
      else if (r < 470) act = ACT_QUERY;
      else if (r < 590) act = ACT_COUNT;
      else if (r < 710) act = ACT_VALUE;
      else if (r < 800) act = ACT_DELETE;
      else if (r < 990) act = ACT_UNIQUE;
      else if (r < 995) act = ACT_CLEAR;
      else act = ACT_UNUSED;
      random_word(k < filling, lt, wl);
      offer(act, lt, wl, $urandom, 0, blank_answer(ST_OK));
    end
  endtask

  // Receiver: random stalls, and one long hold-off when the sender asks for it.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result transaction with no answer pending", $realtime);
        failures++;
      end else begin
        e = pending_answers.pop_front();
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d got %0d", $realtime, e.status, out_status);
          failures++;
        end
        if (out_is_word !== e.is_word) begin
          $display("%0t: is_word expected %0d got %0d", $realtime, e.is_word, out_is_word);
          failures++;
        end
        if (out_prefix_count !== e.count) begin
          $display("%0t: prefix_count expected %0d got %0d", $realtime, e.count,
                   out_prefix_count);
          failures++;
        end
        if (out_value_out !== e.value) begin
          $display("%0t: value_out expected %0d got %0d", $realtime, $signed(e.value),
                   out_value_out);
          failures++;
        end
        if (out_unique_len !== e.ulen) begin
          $display("%0t: unique_len expected %0d got %0d", $realtime, e.ulen,
                   out_unique_len);
          failures++;
        end
      end
    end
  end

  // Watchdog on a generous cycle budget.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    answer_t a;
    empty_trie();
    a = blank_answer(ST_NOT_FOUND);
    rows.push_back('{ACT_QUERY, spell("a"), 1, 0, 1, a});
    rows.push_back('{ACT_INSERT, spell(""), 0, 5, 1, blank_answer(ST_OK)});
    rows.push_back('{ACT_QUERY, spell(""), 0, 0, 0, a});
    rows.push_back('{ACT_COUNT, spell(""), 0, 0, 1, blank_answer(ST_NOT_FOUND)});
    rows.push_back('{ACT_UNIQUE, spell(""), 0, 0, 1, blank_answer(ST_OK)});
    rows.push_back('{ACT_VALUE, spell(""), 0, 0, 0, a});
    rows.push_back('{ACT_INSERT, spell("zzzzzzzzzz"), 10, 32'h7FFF_FFFF, 0, a});
    rows.push_back('{ACT_INSERT, spell("zzzzzzzzzz"), 15, 32'h8000_0000, 0, a});
    rows.push_back('{ACT_VALUE, spell("zzzzzzzzzz"), 12, 0, 0, a});
    rows.push_back('{ACT_INSERT, {LW{1'b1}}, 1, 0, 1, blank_answer(ST_BAD_LETTER)});
    rows.push_back('{ACT_QUERY, {{(LW-5){1'b1}}, 5'd25}, 1, 0, 0, a});
    rows.push_back('{ACT_INSERT, spell("ab"), 2, UNSET, 0, a});
    rows.push_back('{ACT_VALUE, spell("ab"), 2, 0, 0, a});
    rows.push_back('{ACT_INSERT, spell("abc"), 3, 7, 0, a});
    rows.push_back('{ACT_INSERT, spell("ab"), 2, 9, 0, a});
    rows.push_back('{ACT_COUNT, spell("a"), 1, 0, 0, a});
    rows.push_back('{ACT_QUERY, spell("a"), 1, 0, 0, a});
    rows.push_back('{ACT_UNIQUE, spell("abc"), 3, 0, 0, a});
    rows.push_back('{ACT_DELETE, spell("ab"), 2, 0, 0, a});
    rows.push_back('{ACT_QUERY, spell("abc"), 3, 0, 0, a});
    rows.push_back('{ACT_DELETE, spell("q"), 1, 0, 1, blank_answer(ST_NOT_FOUND)});
    rows.push_back('{ACT_UNUSED, {LW{1'b1}}, 4'hF, UNSET, 1, blank_answer(ST_OK)});
    rows.push_back('{ACT_CLEAR, {LW{1'b1}}, 4'hF, 0, 1, blank_answer(ST_OK)});
    rows.push_back('{ACT_QUERY, spell(""), 0, 0, 1, blank_answer(ST_NOT_FOUND)});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    foreach (rows[i])
      offer(rows[i].act, rows[i].letters, rows[i].len, rows[i].value, rows[i].typed,
            rows[i].ans);

    // Receiver stalls more than the sender idles; the receiver then holds off for a long
    // stretch while words keep coming, so the block fills up and stalls its input.
    send_idle = 18;
    recv_idle = 59;
    random_phase(RANDOM_ITEMS / 3, 0);
    hold_req = 1;
    send_idle = 59;
    recv_idle = 18;
    random_phase(RANDOM_ITEMS / 3, 0);
    // Sender pauses until every answer is in, then wide inserts exhaust the node pool.
    drain();
    send_idle = 0;
    recv_idle = 0;
    random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 450);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending_answers.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- trie_dictionary_engine_unit.f -----
rtl/core/tde_pkg.sv
rtl/core/tde_ram.sv
rtl/core/tde_decode.sv
rtl/core/trie_dictionary_engine_unit.sv
tb/sv/trie_dictionary_engine_unit_tb.sv
